// File: src/ffea_pkg.sv
// package for the first-fit extent allocator
// holds payload structs, command and status codes and sizes; no dependencies
package ffea_pkg;

  localparam int MaxExtents = 32;
  localparam int IdxW = $clog2(MaxExtents);
  localparam int CntW = $clog2(MaxExtents + 1);

  localparam logic [1:0] CmdAlloc = 2'd0;
  localparam logic [1:0] CmdFree = 2'd1;
  localparam logic [1:0] CmdGrow = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  localparam logic [0:0] RegHeapBase = 1'd0;
  localparam logic [0:0] RegHeapInit = 1'd1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] block_address;
    logic [31:0] block_size;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
    logic [5:0]  free_extent_count;
  } out_item_t;

  // one stored extent
  typedef struct packed {
    logic        used;
    logic [31:0] start;
    logic [31:0] length;
  } ext_t;

  // per-cell command broadcast by the sequencer
  typedef struct packed {
    logic        seed;
    logic        shift_up;
    logic        shift_down;
    logic        write;
    logic [IdxW-1:0] pos;
    ext_t        data;
  } cell_ctl_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// File: src/first_fit_extent_allocator.sv
// first-fit extent allocator top: sequencer plus chain of extent cells
// depends on ffea_pkg and ffea_cell
//
//  channel | signals                          | direction
//  in      | in_valid, in_ready, in_data      | command in
//  out     | out_valid, out_ready, out_data   | result out
//  cfg     | cfg_we, cfg_index, cfg_wdata     | register write
//
// alloc and free first scan the cells (first-fit or by position), one cell a
// cycle unless a register write stalls it; grow skips the scan. the apply state
// then moves the whole chain, and the next item is taken after the result transfer.
// reset (and any register write) seeds cell 0 with the heap extent at once.
// a result waiting on out_ready holds the block; the next item waits for it.
module first_fit_extent_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ffea_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ffea_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);

  localparam int N = ffea_pkg::MaxExtents;
  localparam int IW = ffea_pkg::IdxW;
  localparam int CW = ffea_pkg::CntW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_APPLY = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  logic [31:0] heap_base, heap_init, heap_length;
  logic [CW-1:0] count;
  ffea_pkg::in_item_t item;
  logic [CW-1:0] scan;
  ffea_pkg::ext_t cells [N];
  ffea_pkg::ext_t prev_ext;
  ffea_pkg::cell_ctl_t ctl;
  ffea_pkg::ext_t seed_val;
  logic [31:0] seed_base, seed_init;
  logic [31:0] result;
  logic [1:0] status;

  // seed values: reset defaults, the register value being written, or the current registers
  assign seed_base = rst ? 32'd0 :
                     (cfg_we && cfg_index == ffea_pkg::RegHeapBase) ? cfg_wdata : heap_base;
  assign seed_init = rst ? 32'd65536 :
                     (cfg_we && cfg_index == ffea_pkg::RegHeapInit) ? cfg_wdata : heap_init;
  assign seed_val = '{used: seed_init != '0, start: seed_base, length: seed_init};

  // chain of cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    ffea_pkg::ext_t lo, hi;
    if (g == 0) begin : g_lo0
      assign lo = '0;
    end else begin : g_lo
      assign lo = cells[g-1];
    end
    if (g == N - 1) begin : g_hiN
      assign hi = '0;
    end else begin : g_hi
      assign hi = cells[g+1];
    end
    ffea_cell u_cell (
      .clk(clk), .rst(rst), .idx(IW'(g)), .ctl(ctl), .seed_val(seed_val),
      .lower(lo), .upper(hi), .ext(cells[g])
    );
  end

  // current scan cell
  ffea_pkg::ext_t cur;
  logic scan_end;
  assign scan_end = (scan >= count);
  assign cur = scan_end ? '0 : cells[scan[IW-1:0]];

  // place decision for free and grow at position scan
  logic [31:0] new_start;
  logic left, right;
  logic [32:0] lsum, rsum;
  assign new_start = (item.command == ffea_pkg::CmdGrow) ?
                     heap_base + heap_length : item.block_address;
  assign lsum = {1'b0, prev_ext.start} + {1'b0, prev_ext.length};
  assign rsum = {1'b0, new_start} + {1'b0, item.block_size};
  assign left = (scan != '0) && lsum == {1'b0, new_start};
  assign right = (item.command == ffea_pkg::CmdFree) && !scan_end &&
                 rsum == {1'b0, cur.start};

  logic scan_hit;
  always_comb begin
    if (item.command == ffea_pkg::CmdAlloc) begin
      scan_hit = scan_end || cur.length >= item.block_size;
    end else if (item.command == ffea_pkg::CmdFree) begin
      scan_hit = scan_end || cur.start > item.block_address;
    end else begin
      scan_hit = scan_end;
    end
  end

  // cell control: seed on a register write, else the update for the apply cycle
  always_comb begin
    ctl = '0;
    ctl.pos = scan[IW-1:0];
    if (cfg_we) begin
      ctl.seed = 1'b1;
    end else if (state == S_APPLY) begin
      case (item.command)
        ffea_pkg::CmdAlloc: begin
          if (!scan_end && item.block_size != '0) begin
            if (cur.length == item.block_size) begin
              ctl.shift_down = 1'b1;
            end else begin
              ctl.write = 1'b1;
              ctl.data = '{used: 1'b1, start: cur.start,
                           length: cur.length - item.block_size};
            end
          end
        end
        ffea_pkg::CmdFree, ffea_pkg::CmdGrow: begin
          if (item.block_size != '0) begin
            if (left) begin
              ctl.pos = scan[IW-1:0] - 1'b1;
              ctl.write = 1'b1;
              ctl.data = '{used: 1'b1, start: prev_ext.start,
                           length: right ? ffea_pkg::sat_add(ffea_pkg::sat_add(
                             prev_ext.length, item.block_size), cur.length) :
                           ffea_pkg::sat_add(prev_ext.length, item.block_size)};
              ctl.shift_down = right;
              if (right) ctl.pos = scan[IW-1:0] - 1'b1;
            end else if (right) begin
              ctl.write = 1'b1;
              ctl.data = '{used: 1'b1, start: new_start,
                           length: ffea_pkg::sat_add(cur.length, item.block_size)};
            end else if (count < CW'(N)) begin
              ctl.shift_up = 1'b1;
              ctl.write = 1'b1;
              ctl.data = '{used: 1'b1, start: new_start, length: item.block_size};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      heap_base <= '0;
      heap_init <= 32'd65536;
      heap_length <= 32'd65536;
      count <= CW'(1);
      out_valid <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == ffea_pkg::RegHeapBase) begin
        heap_base <= cfg_wdata;
        count <= (heap_init != '0) ? CW'(1) : '0;
        heap_length <= heap_init;
      end else begin
        heap_init <= cfg_wdata;
        count <= (cfg_wdata != '0) ? CW'(1) : '0;
        heap_length <= cfg_wdata;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            scan <= '0;
            prev_ext <= '0;
            state <= (in_data.command == ffea_pkg::CmdAlloc ||
                      in_data.command == ffea_pkg::CmdFree) ? S_SCAN : S_APPLY;
            if (in_data.command == ffea_pkg::CmdGrow) begin
              scan <= count;
              prev_ext <= (count == '0) ? '0 : cells[count[IW-1:0] - 1'b1];
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            state <= S_APPLY;
          end else begin
            prev_ext <= cur;
            scan <= scan + 1'b1;
          end
        end
        S_APPLY: begin
          result <= '0;
          status <= ffea_pkg::StOk;
          case (item.command)
            ffea_pkg::CmdAlloc: begin
              if (scan_end) begin
                status <= ffea_pkg::StNoFit;
              end else begin
                result <= cur.start + (cur.length - item.block_size);
                if (item.block_size != '0 && cur.length == item.block_size)
                  count <= count - 1'b1;
              end
            end
            ffea_pkg::CmdFree, ffea_pkg::CmdGrow: begin
              if (item.block_size != '0) begin
                if (left && right) begin
                  count <= count - 1'b1;
                end else if (!left && !right) begin
                  if (count < CW'(N)) count <= count + 1'b1;
                  else status <= ffea_pkg::StFull;
                end
                if (item.command == ffea_pkg::CmdGrow &&
                    (left || count < CW'(N)))
                  heap_length <= heap_length + item.block_size;
              end
            end
            default: ;
          endcase
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE) && !cfg_we;
  assign out_data = '{result_address: result, status: status,
                      free_extent_count: 6'(count)};

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= CW'(N))
    else $error("extent count over capacity");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid == (state == S_OUT)) else $error("out_valid out of step");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_apply_one: assert property (@(posedge clk) disable iff (rst || cfg_we)
    (state == S_APPLY) |=> (state == S_OUT)) else $error("apply not followed by result");

endmodule

// File: src/ffea_cell.sv
// one extent cell of the chain; shifts to its neighbors on insert and removal
// depends on ffea_pkg
module ffea_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [ffea_pkg::IdxW-1:0] idx,
  input  ffea_pkg::cell_ctl_t     ctl,
  input  ffea_pkg::ext_t          seed_val,
  input  ffea_pkg::ext_t          lower,
  input  ffea_pkg::ext_t          upper,
  output ffea_pkg::ext_t          ext
);

  ffea_pkg::ext_t ext_next;

  // select new content
  always_comb begin
    ext_next = ext;
    if (ctl.seed) begin
      ext_next = (idx == '0) ? seed_val : '0;
    end else if (ctl.shift_up && idx > ctl.pos) begin
      ext_next = lower;
    end else if (ctl.shift_down && idx >= ctl.pos) begin
      ext_next = upper;
    end
    if (ctl.write && idx == ctl.pos) begin
      ext_next = ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext <= (idx == '0) ? seed_val : '0;
    end else begin
      ext <= ext_next;
    end
  end

endmodule
